FILE: rtl/tsms_pkg.sv
package tsms_pkg;

   // default widths
   localparam int ADC_BITS_DEFAULT  = 10;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int DUTY_BITS   = 8;
   localparam int DUTY_MAX    = 255;
   localparam int DUR_BITS    = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CENTER_X   = 3'd0,
      CSR_CENTER_Y   = 3'd1,
      CSR_DEFLECTION = 3'd2,
      CSR_DEFLECT_MS = 3'd3,
      CSR_HOLD_MS    = 3'd4,
      CSR_BRAKE_MS   = 3'd5
   } csr_index_type;

   // register reset values
   localparam logic [DUTY_BITS-1:0] CENTER_X_RESET   = 8'd128;
   localparam logic [DUTY_BITS-1:0] CENTER_Y_RESET   = 8'd128;
   localparam logic [DUTY_BITS-1:0] DEFLECTION_RESET = 8'd60;
   localparam logic [DUR_BITS-1:0]  DEFLECT_MS_RESET = 16'd400;
   localparam logic [DUR_BITS-1:0]  HOLD_MS_RESET    = 16'd500;
   localparam logic [DUR_BITS-1:0]  BRAKE_MS_RESET   = 16'd100;

   // maneuver phases; each direction runs deflect, hold, brake, settle
   typedef enum logic [4:0] {
      PH_IDLE          = 5'd0,
      PH_FWD_DEFLECT   = 5'd1,
      PH_FWD_BRAKE     = 5'd2,
      PH_FWD_HOLD      = 5'd3,
      PH_FWD_SETTLE    = 5'd4,
      PH_BACK_DEFLECT  = 5'd5,
      PH_BACK_BRAKE    = 5'd6,
      PH_BACK_HOLD     = 5'd7,
      PH_BACK_SETTLE   = 5'd8,
      PH_RIGHT_DEFLECT = 5'd9,
      PH_RIGHT_BRAKE   = 5'd10,
      PH_RIGHT_HOLD    = 5'd11,
      PH_RIGHT_SETTLE  = 5'd12,
      PH_LEFT_DEFLECT  = 5'd13,
      PH_LEFT_BRAKE    = 5'd14,
      PH_LEFT_HOLD     = 5'd15,
      PH_LEFT_SETTLE   = 5'd16
   } phase_type;

   function automatic logic [DUTY_BITS-1:0] plus_sat(input logic [DUTY_BITS-1:0] c,
                                                     input logic [DUTY_BITS-1:0] d);
      logic [DUTY_BITS:0] sum;
      sum = {1'b0, c} + {1'b0, d};
      return sum[DUTY_BITS] ? DUTY_BITS'(DUTY_MAX) : sum[DUTY_BITS-1:0];
   endfunction

   function automatic logic [DUTY_BITS-1:0] minus_sat(input logic [DUTY_BITS-1:0] c,
                                                      input logic [DUTY_BITS-1:0] d);
      return (d > c) ? '0 : c - d;
   endfunction

endpackage

FILE: rtl/timed_stick_maneuver_sequencer_core.sv
// Stick drive sequencer: every request transaction (timestamp, mode bit, four joystick
// samples) yields exactly one response transaction with four 8-bit drive values and the
// phase after the step. Samples are scaled to 0..255 (x*255/full scale, truncated). In
// manual mode all four outputs follow the samples and the sequencer drops to idle; in
// auto mode the right stick runs the timed forward/back/right/left pattern set by the
// csr registers, and a timed phase advances once the wrapped elapsed time since the last
// switch exceeds its duration. Throughput is one transaction per clock while rsp_ready
// does not hold the response register full; a request passes the input register, then
// the response register, whose load raises rsp_valid. The phase and switch-time state
// are updated as an item enters the response register. Write csr registers only while
// no transaction is in flight.
module timed_stick_maneuver_sequencer_core
   import tsms_pkg::*;
#(
   parameter int ADC_BITS  = ADC_BITS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [TIME_BITS-1:0]     req_now_ms,
   input  logic                     req_auto_mode,
   input  logic [ADC_BITS-1:0]      req_left_x_sample,
   input  logic [ADC_BITS-1:0]      req_left_y_sample,
   input  logic [ADC_BITS-1:0]      req_right_x_sample,
   input  logic [ADC_BITS-1:0]      req_right_y_sample,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DUTY_BITS-1:0]     rsp_left_x_duty,
   output logic [DUTY_BITS-1:0]     rsp_left_y_duty,
   output logic [DUTY_BITS-1:0]     rsp_right_x_duty,
   output logic [DUTY_BITS-1:0]     rsp_right_y_duty,
   output logic [4:0]               rsp_phase_now
);

   localparam int PROD_BITS = ADC_BITS + DUTY_BITS + 1;

   // x*255 / (2^N - 1): exact for products below 2^(2N)
   function automatic logic [DUTY_BITS-1:0] scale_sample(input logic [ADC_BITS-1:0] s);
      logic [PROD_BITS-1:0] prod;
      logic [PROD_BITS-1:0] sum;
      prod = PROD_BITS'(s) * PROD_BITS'(DUTY_MAX);
      sum  = prod + (prod >> ADC_BITS) + PROD_BITS'(1);
      return sum[ADC_BITS+DUTY_BITS-1:ADC_BITS];
   endfunction

   // configuration registers
   logic [DUTY_BITS-1:0] center_x_ff, center_y_ff, deflection_ff;
   logic [DUR_BITS-1:0]  deflect_ms_ff, hold_ms_ff, brake_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= CENTER_X_RESET;
         center_y_ff   <= CENTER_Y_RESET;
         deflection_ff <= DEFLECTION_RESET;
         deflect_ms_ff <= DEFLECT_MS_RESET;
         hold_ms_ff    <= HOLD_MS_RESET;
         brake_ms_ff   <= BRAKE_MS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:   center_x_ff   <= csr_wdata[DUTY_BITS-1:0];
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata[DUTY_BITS-1:0];
            CSR_DEFLECTION: deflection_ff <= csr_wdata[DUTY_BITS-1:0];
            CSR_DEFLECT_MS: deflect_ms_ff <= csr_wdata;
            CSR_HOLD_MS:    hold_ms_ff    <= csr_wdata;
            CSR_BRAKE_MS:   brake_ms_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register stage
   logic                 s1_valid_ff;
   logic [TIME_BITS-1:0] s1_now_ff;
   logic                 s1_auto_ff;
   logic [ADC_BITS-1:0]  s1_lx_ff, s1_ly_ff, s1_rx_ff, s1_ry_ff;
   logic                 s1_advance;
   logic                 rsp_valid_ff;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_now_ff  <= req_now_ms;
         s1_auto_ff <= req_auto_mode;
         s1_lx_ff   <= req_left_x_sample;
         s1_ly_ff   <= req_left_y_sample;
         s1_rx_ff   <= req_right_x_sample;
         s1_ry_ff   <= req_right_y_sample;
      end
   end

   // sequencer state
   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] last_ff, last_in;

   logic [TIME_BITS-1:0] elapsed;
   logic [DUR_BITS-1:0]  dur;
   logic [DUTY_BITS-1:0] pat_rx, pat_ry;
   phase_type            seq_next;

   assign elapsed = s1_now_ff - last_ff;

   // pattern outputs and phase duration
   always_comb begin
      pat_rx = center_x_ff;
      pat_ry = center_y_ff;
      dur    = hold_ms_ff;
      case (phase_ff)
         PH_FWD_DEFLECT: begin
            pat_ry = minus_sat(center_y_ff, deflection_ff);
            dur    = deflect_ms_ff;
         end
         PH_FWD_BRAKE: begin
            pat_ry = plus_sat(center_y_ff, deflection_ff);
            dur    = brake_ms_ff;
         end
         PH_BACK_DEFLECT: begin
            pat_ry = plus_sat(center_y_ff, deflection_ff);
            dur    = deflect_ms_ff;
         end
         PH_BACK_BRAKE: begin
            pat_ry = minus_sat(center_y_ff, deflection_ff);
            dur    = brake_ms_ff;
         end
         PH_RIGHT_DEFLECT: begin
            pat_rx = minus_sat(center_x_ff, deflection_ff);
            dur    = deflect_ms_ff;
         end
         PH_RIGHT_BRAKE: begin
            pat_rx = plus_sat(center_x_ff, deflection_ff);
            dur    = brake_ms_ff;
         end
         PH_LEFT_DEFLECT: begin
            pat_rx = plus_sat(center_x_ff, deflection_ff);
            dur    = deflect_ms_ff;
         end
         PH_LEFT_BRAKE: begin
            pat_rx = minus_sat(center_x_ff, deflection_ff);
            dur    = brake_ms_ff;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      case (phase_ff)
         PH_IDLE:          seq_next = PH_FWD_DEFLECT;
         PH_FWD_DEFLECT:   seq_next = PH_FWD_HOLD;
         PH_FWD_HOLD:      seq_next = PH_FWD_BRAKE;
         PH_FWD_BRAKE:     seq_next = PH_FWD_SETTLE;
         PH_FWD_SETTLE:    seq_next = PH_BACK_DEFLECT;
         PH_BACK_DEFLECT:  seq_next = PH_BACK_HOLD;
         PH_BACK_HOLD:     seq_next = PH_BACK_BRAKE;
         PH_BACK_BRAKE:    seq_next = PH_BACK_SETTLE;
         PH_BACK_SETTLE:   seq_next = PH_RIGHT_DEFLECT;
         PH_RIGHT_DEFLECT: seq_next = PH_RIGHT_HOLD;
         PH_RIGHT_HOLD:    seq_next = PH_RIGHT_BRAKE;
         PH_RIGHT_BRAKE:   seq_next = PH_RIGHT_SETTLE;
         PH_RIGHT_SETTLE:  seq_next = PH_LEFT_DEFLECT;
         PH_LEFT_DEFLECT:  seq_next = PH_LEFT_HOLD;
         PH_LEFT_HOLD:     seq_next = PH_LEFT_BRAKE;
         PH_LEFT_BRAKE:    seq_next = PH_LEFT_SETTLE;
         default:          seq_next = PH_IDLE;
      endcase

      phase_in = phase_ff;
      last_in  = last_ff;
      if (!s1_auto_ff) begin
         phase_in = PH_IDLE;
      end else if (phase_ff == PH_IDLE) begin
         phase_in = seq_next;
         last_in  = s1_now_ff;
      end else if (phase_ff > PH_LEFT_SETTLE) begin
         // stray code: back to idle without stamping the time
         phase_in = PH_IDLE;
      end else if (elapsed > TIME_BITS'(dur)) begin
         phase_in = seq_next;
         last_in  = s1_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         last_ff  <= '0;
      end else if (s1_advance) begin
         phase_ff <= phase_in;
         last_ff  <= last_in;
      end
   end

   // response register
   logic [DUTY_BITS-1:0] lx_duty_ff, ly_duty_ff, rx_duty_ff, ry_duty_ff;
   logic [4:0]           phase_now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         lx_duty_ff   <= scale_sample(s1_lx_ff);
         ly_duty_ff   <= scale_sample(s1_ly_ff);
         rx_duty_ff   <= s1_auto_ff ? pat_rx : scale_sample(s1_rx_ff);
         ry_duty_ff   <= s1_auto_ff ? pat_ry : scale_sample(s1_ry_ff);
         phase_now_ff <= phase_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_x_duty  = lx_duty_ff;
   assign rsp_left_y_duty  = ly_duty_ff;
   assign rsp_right_x_duty = rx_duty_ff;
   assign rsp_right_y_duty = ry_duty_ff;
   assign rsp_phase_now    = phase_now_ff;

`ifndef ASSERT_OFF
   // manual transaction always leaves the sequencer idle
   a_manual_idle: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_auto_ff |=> phase_ff == PH_IDLE)
      else $error("manual transaction did not return sequencer to idle");

   // an item leaving the input stage lands in the response register
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("advanced item missing from response register");

   // sequencer state moves only with a transaction
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> $stable(phase_ff) && $stable(last_ff))
      else $error("sequencer state changed without a transaction");

   // auto start from idle enters forward deflect and stamps the time
   a_auto_start: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_auto_ff && phase_ff == PH_IDLE
      |=> phase_ff == PH_FWD_DEFLECT && last_ff == $past(s1_now_ff))
      else $error("auto start from idle mishandled");
`endif

endmodule
